>>> hw/rtl/hrpp_pkg.sv
`default_nettype none
package hrpp_pkg;

	localparam int MAX_RES = 6;
	localparam int CNT_W = 3;

	localparam logic [15:0] LIMIT_RESET = 16'd1200;
	localparam logic [5:0] AP_TYPE = 6'd48;
	localparam logic [5:0] FU_TYPE = 6'd49;

	// NAL handling mode between bytes of one NAL unit.
	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_SINGLE = 4'b0010,
		MODE_AGG    = 4'b0100,
		MODE_FRAG   = 4'b1000
	} mode_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
		logic [15:0] nal_size;
		logic        next_present;
		logic [15:0] next_size;
	} item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        has_byte;
		logic        packet_start;
		logic        packet_end;
		logic [15:0] sequence_res;
		logic        run_last;
	} ent_t;

	typedef struct packed {
		ent_t [MAX_RES-1:0] ent;
		logic [CNT_W-1:0]   cnt;
	} list_t;

	function automatic ent_t mk_ent(logic [7:0] b, logic has, logic st, logic en,
		logic [15:0] seq);
		ent_t e;
		e.out_byte     = b;
		e.has_byte     = has;
		e.packet_start = st;
		e.packet_end   = en;
		e.sequence_res = seq - 16'd1;
		e.run_last     = 1'b0;
		return e;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hrpp_core.sv
`default_nettype none
module hrpp_core
	import hrpp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire item_t       item,
	input  wire logic [15:0] limit,
	input  wire logic        list_ready,
	output logic             take,
	output list_t            list
);

	mode_t       mode_q, mode_c;
	logic [15:0] bseen_q, bseen_c;
	logic [7:0]  held_q, held_c;
	logic [14:0] hf_q, hf_c;
	logic        aopen_q, aopen_c;
	logic [16:0] afill_q, afill_c;
	logic [15:0] ffill_q, ffill_c;
	logic [15:0] seq_q, seq_c;

	logic [15:0]      cur, eff, mx, rem;
	logic             last, fu_end, fu_s, fu_e;
	logic [5:0]       hlayer;
	logic [7:0]       b;
	logic [CNT_W-1:0] n;
	list_t            lst;

	assign take = item_valid && list_ready;
	assign list = lst;

	always_comb begin
		mode_c  = mode_q;
		bseen_c = bseen_q;
		held_c  = held_q;
		hf_c    = hf_q;
		aopen_c = aopen_q;
		afill_c = afill_q;
		ffill_c = ffill_q;
		seq_c   = seq_q;
		lst     = '0;
		n       = '0;
		b       = item.data_byte;
		eff     = (item.nal_size < 16'd2) ? 16'd2 : item.nal_size;
		mx      = (limit > 16'd3) ? (limit - 16'd3) : 16'd1;
		cur     = (mode_q == MODE_IDLE) ? 16'd0 : bseen_q;
		last    = ({1'b0, cur} + 17'd1) >= {1'b0, eff};
		hlayer  = hf_q[8:3];
		rem     = (eff > cur) ? (eff - cur) : 16'd1;
		fu_s    = (cur == 16'd2);
		fu_e    = (rem <= mx);
		fu_end  = (({1'b0, ffill_q} + 17'd1) >= {1'b0, mx}) || last;

		if (item.command) begin
			if (mode_q == MODE_IDLE && aopen_q) begin
				lst.ent[n] = mk_ent(8'd0, 1'b0, 1'b0, 1'b1, seq_c);
				n = n + 1'b1;
				aopen_c = 1'b0;
				afill_c = '0;
			end
		end else begin
			if (cur == 16'd1)
				hf_c = {held_q[6:1], held_q[0], b[7:3], b[2:0]};

			unique case (mode_q)
				MODE_IDLE: begin
					held_c = b;
					if (eff < limit) begin
						if (aopen_c && ({1'b0, afill_c} + 18'd2 + {2'b0, eff}) > {2'b0, limit})
						begin
							lst.ent[n] = mk_ent(8'd0, 1'b0, 1'b0, 1'b1, seq_c);
							n = n + 1'b1;
							aopen_c = 1'b0;
							afill_c = '0;
						end
						if (!aopen_c && item.next_present &&
							(18'd6 + {2'b0, eff} + {2'b0, item.next_size}) <= {2'b0, limit})
						begin
							mode_c = MODE_AGG;
						end else if (aopen_c) begin
							mode_c  = MODE_AGG;
							afill_c = afill_c + 17'd2 + {1'b0, eff};
							lst.ent[n] = mk_ent(eff[15:8], 1'b1, 1'b0, 1'b0, seq_c);
							n = n + 1'b1;
							lst.ent[n] = mk_ent(eff[7:0], 1'b1, 1'b0, 1'b0, seq_c);
							n = n + 1'b1;
							lst.ent[n] = mk_ent(b, 1'b1, 1'b0, 1'b0, seq_c);
							n = n + 1'b1;
						end else begin
							mode_c = MODE_SINGLE;
							seq_c  = seq_c + 16'd1;
							lst.ent[n] = mk_ent(b, 1'b1, 1'b1, last, seq_c);
							n = n + 1'b1;
						end
					end else begin
						if (aopen_c) begin
							lst.ent[n] = mk_ent(8'd0, 1'b0, 1'b0, 1'b1, seq_c);
							n = n + 1'b1;
							aopen_c = 1'b0;
							afill_c = '0;
						end
						mode_c  = MODE_FRAG;
						ffill_c = '0;
					end
				end
				MODE_SINGLE: begin
					lst.ent[n] = mk_ent(b, 1'b1, 1'b0, last, seq_c);
					n = n + 1'b1;
				end
				MODE_AGG: begin
					// The AP header needs the layer id, so it goes out with byte 1.
					if (cur == 16'd1 && !aopen_q) begin
						seq_c   = seq_c + 16'd1;
						aopen_c = 1'b1;
						afill_c = 17'd4 + {1'b0, eff};
						lst.ent[n] = mk_ent({1'b0, AP_TYPE, held_q[0]}, 1'b1, 1'b1, 1'b0, seq_c);
						n = n + 1'b1;
						lst.ent[n] = mk_ent(b, 1'b1, 1'b0, 1'b0, seq_c);
						n = n + 1'b1;
						lst.ent[n] = mk_ent(eff[15:8], 1'b1, 1'b0, 1'b0, seq_c);
						n = n + 1'b1;
						lst.ent[n] = mk_ent(eff[7:0], 1'b1, 1'b0, 1'b0, seq_c);
						n = n + 1'b1;
						lst.ent[n] = mk_ent(held_q, 1'b1, 1'b0, 1'b0, seq_c);
						n = n + 1'b1;
						lst.ent[n] = mk_ent(b, 1'b1, 1'b0, 1'b0, seq_c);
						n = n + 1'b1;
					end else begin
						lst.ent[n] = mk_ent(b, 1'b1, 1'b0, 1'b0, seq_c);
						n = n + 1'b1;
					end
				end
				MODE_FRAG: begin
					// The two NAL header bytes are dropped; the FU header replaces them.
					if (cur >= 16'd2) begin
						if (ffill_q == 16'd0) begin
							seq_c = seq_c + 16'd1;
							lst.ent[n] = mk_ent({1'b0, FU_TYPE, hlayer[5]}, 1'b1, 1'b1, 1'b0,
								seq_c);
							n = n + 1'b1;
							lst.ent[n] = mk_ent({hlayer[4:0], hf_q[2:0]}, 1'b1, 1'b0, 1'b0,
								seq_c);
							n = n + 1'b1;
							lst.ent[n] = mk_ent({fu_s, fu_e, hf_q[14:9]}, 1'b1, 1'b0, 1'b0,
								seq_c);
							n = n + 1'b1;
						end
						lst.ent[n] = mk_ent(b, 1'b1, 1'b0, fu_end, seq_c);
						n = n + 1'b1;
						ffill_c = fu_end ? 16'd0 : (ffill_q + 16'd1);
					end
				end
				default: begin
					mode_c = MODE_IDLE;
				end
			endcase

			if (last) begin
				mode_c  = MODE_IDLE;
				bseen_c = '0;
				ffill_c = '0;
			end else begin
				bseen_c = cur + 16'd1;
			end
		end

		if (n != '0)
			lst.ent[n - 1'b1].run_last = 1'b1;
		lst.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			bseen_q <= '0;
			held_q  <= '0;
			hf_q    <= '0;
			aopen_q <= 1'b0;
			afill_q <= '0;
			ffill_q <= '0;
			seq_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_c;
			bseen_q <= bseen_c;
			held_q  <= held_c;
			hf_q    <= hf_c;
			aopen_q <= aopen_c;
			afill_q <= afill_c;
			ffill_q <= ffill_c;
			seq_q   <= seq_c;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/hrpp_emit.sv
`default_nettype none
module hrpp_emit
	import hrpp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire list_t list,
	output logic       list_ready,
	output logic       out_valid,
	input  wire logic  out_stall,
	output ent_t       out_ent
);

	ent_t [MAX_RES-1:0] lst_q;
	logic [CNT_W-1:0]   rem_q;
	logic               out_valid_q;
	ent_t               out_q;
	logic               pop;

	assign pop        = (rem_q != '0) && (!out_valid_q || !out_stall);
	assign list_ready = (rem_q == '0) || ((rem_q == CNT_W'(1)) && pop);
	assign out_valid  = out_valid_q;
	assign out_ent    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (load)
				rem_q <= list.cnt;
			else if (pop)
				rem_q <= rem_q - 1'b1;
		end
	end

	// Words leave from the bottom of the list; the rest shifts down one place.
	always_ff @(posedge clk) begin
		if (pop)
			out_q <= lst_q[0];
		if (load) begin
			lst_q <= list.ent;
		end else if (pop) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				lst_q[i] <= lst_q[i + 1];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/hevc_rtp_payload_packetizer_unit.sv
// HEVC RTP payload packetizer.
// Input channel (in_valid/in_stall): one word per NAL byte with the NAL's size and
// the size of the following NAL, or a flush command that closes an open aggregation.
// Output channel (out_valid/out_stall): one word per payload byte or bare end mark,
// with packet start/end flags, the RTP sequence number and a last-of-item flag.
// payload_limit is written over the APB port at byte address 0. The user must write it
// only while the block is idle; the block itself does not enforce this.
// The first word caused by an input word passes the input register, the result list
// and the output register, which emits one word per cycle while the receiver does
// not stall: plain payload bytes stream at one per cycle, and header insertion (up to
// six words) holds the input until its words are emitted. Input words giving no
// output still pass through the decision stage. A stalled receiver holds the output
// word; the result list backs up and then in_stall rises. Reset clears all packetizer
// state, the sequence number and any pending words, and sets payload_limit to 1200.
`default_nettype none
module hevc_rtp_payload_packetizer_unit
	import hrpp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] nal_size,
	input  wire logic        next_present,
	input  wire logic [15:0] next_size,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             has_byte,
	output logic             packet_start,
	output logic             packet_end,
	output logic [15:0]      sequence_res,
	output logic             run_last
);

	logic [15:0] limit_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        take;
	logic        list_ready;
	list_t       list;
	ent_t        out_ent;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
			limit_q <= pwdata[15:0];
	end

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.command      <= command;
			item_s1.data_byte    <= data_byte;
			item_s1.nal_size     <= nal_size;
			item_s1.next_present <= next_present;
			item_s1.next_size    <= next_size;
		end
	end

	hrpp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.limit      (limit_q),
		.list_ready (list_ready),
		.take       (take),
		.list       (list)
	);

	hrpp_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.list       (list),
		.list_ready (list_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_ent    (out_ent)
	);

	assign out_byte     = out_ent.out_byte;
	assign has_byte     = out_ent.has_byte;
	assign packet_start = out_ent.packet_start;
	assign packet_end   = out_ent.packet_end;
	assign sequence_res = out_ent.sequence_res;
	assign run_last     = out_ent.run_last;

endmodule
`default_nettype wire
